// ===== hdl/sd_spi_host_sequencer_macros.svh =====
// assertion helpers for the sd spi host sequencer
`ifndef SD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_SPI_HOST_SEQUENCER_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define SDS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SDS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// types, constants and helpers shared by the sd spi host sequencer
// ----------------------------------------------------------------------------
package sds_pkg;

   localparam int BlockBytes = 512;
   localparam int CountBitsDefault = 16;

   typedef enum logic [2:0] {
      FUNC_INIT  = 3'd0,
      FUNC_READ  = 3'd1,
      FUNC_WRITE = 3'd2,
      FUNC_XCHG  = 3'd3,
      FUNC_WDATA = 3'd4
   } func_type;

   typedef enum logic [0:0] {
      CSR_POLL_LIMIT  = 1'd0,
      CSR_RETRY_LIMIT = 1'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_OK     = 4'd0,
      ST_CMD0   = 4'd1,
      ST_CMD8   = 4'd2,
      ST_ACMD41 = 4'd3,
      ST_CMD58  = 4'd4,
      ST_NOT_HC = 4'd5,
      ST_R1_REJ = 4'd6,
      ST_TOKEN  = 4'd7,
      ST_WR_REJ = 4'd8
   } status_type;

   typedef enum logic [5:0] {
      PH_IDLE, PH_WAKE, PH_C0, PH_C8, PH_C55, PH_C41, PH_C58, PH_RDCMD, PH_C12,
      PH_WC23, PH_WRCMD, PH_RDTOK, PH_RDDATA, PH_RDCRC, PH_RDEND, PH_RDTAIL,
      PH_WTOK, PH_WREQ, PH_WDATA, PH_WCRC, PH_WDRESP, PH_WBUSY, PH_WSTOP,
      PH_WTAIL, PH_WREJ
   } phase_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] sector;
      logic [15:0] count;
      logic [7:0]  rx_byte;
      logic [7:0]  wr_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       cs_low;
      logic       rd_valid;
      logic [7:0] rd_byte;
      logic       need_wr;
      logic       done_res;
      logic [3:0] status;
      logic       last;
   } rsp_type;

   function automatic logic is_cmd(input phase_type p);
      return (p >= PH_C0) && (p <= PH_WRCMD);
   endfunction

endpackage

// ===== hdl/sd_spi_host_sequencer.sv =====
// a result is registered and appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle; the single step of the sequencer core
// sets it, and input stalls only while a waiting result is itself stalled
// a request that causes no result gives none and leaves the state alone
// reset: synchronous; state idle, limits 4095 polls and 255 retries
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// sd card spi-mode host sequencer, one step per exchanged byte
// ----------------------------------------------------------------------------
`include "sd_spi_host_sequencer_macros.svh"
module sd_spi_host_sequencer
   import sds_pkg::*;
#(
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] poll_ff;
   logic [7:0]  retry_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        step_en, emit;
   logic [15:0] poll_eff;
   logic [7:0]  retry_eff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_ff  <= 16'd4095;
         retry_ff <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLL_LIMIT:  poll_ff  <= csr_wdata;
            CSR_RETRY_LIMIT: retry_ff <= csr_wdata[7:0];
            default:         poll_ff  <= poll_ff;
         endcase
      end
   end

   // a zero limit acts as one
   assign poll_eff  = (poll_ff == 0) ? 16'd1 : poll_ff;
   assign retry_eff = (retry_ff == 0) ? 8'd1 : retry_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step_en   = req_valid && !req_stall;

   sds_core #(.COUNT_BITS(COUNT_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .req        (req_data),
      .poll_limit (poll_eff),
      .retry_limit(retry_eff),
      .emit       (emit),
      .rsp        (rsp_data_in)
   );

   // result register
   assign rsp_valid_in = (step_en && emit) || (rsp_valid_ff && rsp_stall);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   always_ff @(posedge clock) begin
      if (step_en && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `SDS_ASSERT_IMP(a_stall_when_full, rsp_valid_ff && rsp_stall, req_stall, "input not held")
   `SDS_ASSERT_NXT(a_hold_result, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled result changed")
   `SDS_ASSERT_IMP(a_last_set, rsp_valid, rsp_data.last, "last flag missing")

endmodule

// ===== hdl/sds_core.sv =====
// ----------------------------------------------------------------------------
// sds_core
// sequencer state and per-transaction step logic; while step_en is high, one decision per cycle
// ----------------------------------------------------------------------------
module sds_core
   import sds_pkg::*;
#(
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  req_type     req,
   input  logic [15:0] poll_limit,
   input  logic [7:0]  retry_limit,
   output logic        emit,
   output rsp_type     rsp
);

   localparam int IdxBits = $clog2(BlockBytes) + 1;

   phase_type              phase_ff, phase_in;
   logic [IdxBits-1:0]     idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  blocks_ff, blocks_in;
   logic [7:0]             retries_ff, retries_in;
   logic [15:0]            polls_ff, polls_in;
   logic [7:0]             stok_ff, stok_in;
   logic                   multi_ff, multi_in;
   logic [7:0]             ocr_ff, ocr_in;
   logic [31:0]            arg_ff, arg_in;
   logic [7:0]             resp_ff, resp_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         idx_ff     <= '0;
         blocks_ff  <= '0;
         retries_ff <= '0;
         polls_ff   <= '0;
         stok_ff    <= 8'hFF;
         multi_ff   <= 1'b0;
         ocr_ff     <= '0;
         arg_ff     <= '0;
         resp_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         blocks_ff  <= blocks_in;
         retries_ff <= retries_in;
         polls_ff   <= polls_in;
         stok_ff    <= stok_in;
         multi_ff   <= multi_in;
         ocr_ff     <= ocr_in;
         arg_ff     <= arg_in;
         resp_ff    <= resp_in;
      end
   end

   // next state and result of one transaction
   always_comb begin
      logic [7:0]  rx;
      logic        fin;
      logic [3:0]  fst;
      logic        direct, rdv, cs;
      logic [7:0]  tx, fidx, fcrc;
      logic [31:0] farg;
      logic        ent;
      phase_type   ep;
      logic [COUNT_BITS-1:0] bdec;
      logic [1:0]  tail_n;
      rx = req.rx_byte;
      fin = 1'b0; fst = ST_OK; direct = 1'b0; rdv = 1'b0;
      ent = 1'b0; ep = PH_IDLE;
      tx = 8'hFF; cs = 1'b0; fidx = '0; farg = '0; fcrc = '0;
      bdec = blocks_ff - 1'b1;
      tail_n = multi_ff ? 2'd3 : 2'd2;
      phase_in = phase_ff; idx_in = idx_ff; blocks_in = blocks_ff;
      retries_in = retries_ff; polls_in = polls_ff; stok_in = stok_ff;
      multi_in = multi_ff; ocr_in = ocr_ff; arg_in = arg_ff; resp_in = resp_ff;
      emit = 1'b0;

      case (req.func)
         FUNC_INIT, FUNC_READ, FUNC_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               emit = 1'b1;
               ent = 1'b1;
               if (req.func == FUNC_INIT) begin
                  ep = PH_WAKE;
               end else begin
                  blocks_in = COUNT_BITS'(req.count);
                  multi_in = (blocks_in != COUNT_BITS'(1));
                  arg_in = req.sector;
                  if (req.func == FUNC_READ) begin
                     ep = PH_RDCMD;
                  end else begin
                     stok_in = multi_in ? 8'hFC : 8'hFE;
                     ep = multi_in ? PH_WC23 : PH_WRCMD;
                  end
               end
            end
         end
         FUNC_XCHG: begin
            if (phase_ff != PH_IDLE && phase_ff != PH_WREQ) begin
               emit = 1'b1;
               rdv = (phase_ff == PH_RDDATA);
               if (is_cmd(phase_ff)) begin
                  if (idx_ff < 5) begin
                     idx_in = idx_ff + 1'b1;
                  end else if (idx_ff == 5) begin
                     idx_in = IdxBits'(6);
                     polls_in = poll_limit;
                  end else if (idx_ff == 6) begin
                     if (rx == 8'hFF && polls_ff > 1) begin
                        polls_in = polls_ff - 1'b1;
                     end else begin
                        resp_in = rx;
                        if (phase_ff == PH_C8 || phase_ff == PH_C58) begin
                           idx_in = IdxBits'(7);
                        end else if (phase_ff == PH_RDCMD && rx == 8'h00) begin
                           ent = 1'b1; ep = (blocks_ff != 0) ? PH_RDTOK : PH_RDEND;
                        end else if (phase_ff == PH_WRCMD && rx == 8'h00) begin
                           ent = 1'b1; ep = (blocks_ff != 0) ? PH_WTOK : PH_WSTOP;
                        end else begin
                           idx_in = IdxBits'(11);
                        end
                     end
                  end else if (idx_ff < 11) begin
                     if (idx_ff == 7 && phase_ff == PH_C58) ocr_in = rx;
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_C0: begin
                           if (resp_ff != 8'h01) begin fin = 1'b1; fst = ST_CMD0; end
                           else begin ent = 1'b1; ep = PH_C8; end
                        end
                        PH_C8: begin
                           if (resp_ff != 8'h01) begin fin = 1'b1; fst = ST_CMD8; end
                           else begin
                              retries_in = retry_limit; ent = 1'b1; ep = PH_C55;
                           end
                        end
                        PH_C55: begin
                           if (resp_ff != 8'h01) begin fin = 1'b1; fst = ST_ACMD41; end
                           else begin ent = 1'b1; ep = PH_C41; end
                        end
                        PH_C41: begin
                           if (resp_ff == 8'h00) begin
                              retries_in = retry_limit; ent = 1'b1; ep = PH_C58;
                           end else if (retries_ff <= 1) begin
                              fin = 1'b1; fst = ST_ACMD41;
                           end else begin
                              retries_in = retries_ff - 1'b1; ent = 1'b1; ep = PH_C55;
                           end
                        end
                        PH_C58: begin
                           if (resp_ff == 8'h00) begin
                              fin = 1'b1; fst = ocr_ff[6] ? ST_OK : ST_NOT_HC;
                           end else if (retries_ff <= 1) begin
                              fin = 1'b1; fst = ST_CMD58;
                           end else begin
                              retries_in = retries_ff - 1'b1; ent = 1'b1; ep = PH_C58;
                           end
                        end
                        PH_C12:  begin ent = 1'b1; ep = PH_RDTAIL; end
                        PH_WC23: begin ent = 1'b1; ep = PH_WRCMD; end
                        default: begin fin = 1'b1; fst = ST_R1_REJ; end
                     endcase
                  end
               end else begin
                  case (phase_ff)
                     PH_WAKE: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= 10) begin ent = 1'b1; ep = PH_C0; end
                     end
                     PH_RDTOK: begin
                        if (rx == 8'hFF && polls_ff > 1) polls_in = polls_ff - 1'b1;
                        else begin ent = 1'b1; ep = (rx == 8'hFE) ? PH_RDDATA : PH_RDEND; end
                     end
                     PH_RDDATA: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= BlockBytes) begin ent = 1'b1; ep = PH_RDCRC; end
                     end
                     PH_RDCRC: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= 2) begin
                           blocks_in = bdec; ent = 1'b1;
                           ep = (bdec != 0) ? PH_RDTOK : PH_RDEND;
                        end
                     end
                     PH_RDEND: begin
                        if (!multi_ff) begin
                           fin = 1'b1; fst = (blocks_ff != 0) ? ST_TOKEN : ST_OK;
                        end else begin ent = 1'b1; ep = PH_C12; end
                     end
                     PH_RDTAIL: begin
                        fin = 1'b1; fst = (blocks_ff != 0) ? ST_TOKEN : ST_OK;
                     end
                     PH_WTOK: begin ent = 1'b1; ep = PH_WREQ; end
                     PH_WDATA: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= BlockBytes) begin ent = 1'b1; ep = PH_WCRC; end
                        else phase_in = PH_WREQ;
                     end
                     PH_WCRC: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= 2) begin ent = 1'b1; ep = PH_WDRESP; end
                     end
                     PH_WDRESP: begin
                        ent = 1'b1; ep = (rx[4:0] == 5'h05) ? PH_WBUSY : PH_WREJ;
                     end
                     PH_WBUSY: begin
                        if (rx != 8'h00) begin
                           blocks_in = bdec; ent = 1'b1;
                           if (bdec != 0) ep = PH_WTOK;
                           else ep = multi_ff ? PH_WSTOP : PH_WTAIL;
                        end
                     end
                     PH_WSTOP: begin ent = 1'b1; ep = PH_WTAIL; end
                     PH_WTAIL: begin
                        idx_in = idx_ff + 1'b1;
                        if (idx_in >= IdxBits'(tail_n)) begin fin = 1'b1; fst = ST_OK; end
                     end
                     default: begin fin = 1'b1; fst = ST_WR_REJ; end
                  endcase
               end
            end
         end
         FUNC_WDATA: begin
            if (phase_ff == PH_WREQ) begin
               emit = 1'b1; direct = 1'b1; phase_in = PH_WDATA;
            end
         end
         default: emit = 1'b0;
      endcase

      // phase entry resets index and poll budget
      if (ent) begin
         phase_in = ep; idx_in = '0; polls_in = poll_limit;
      end
      if (fin) phase_in = PH_IDLE;

      // command frame for the phase being entered
      case (phase_in)
         PH_C0:    fcrc = 8'h95;
         PH_C8:    begin fidx = 8'd8; farg = 32'h0000_01AA; fcrc = 8'h87; end
         PH_C55:   fidx = 8'd55;
         PH_C41:   begin fidx = 8'd41; farg = 32'h4000_0000; end
         PH_C58:   begin fidx = 8'd58; fcrc = 8'h01; end
         PH_RDCMD: begin fidx = multi_in ? 8'd18 : 8'd17; farg = arg_in; end
         PH_C12:   fidx = 8'd12;
         PH_WC23:  begin fidx = 8'd23; farg = 32'(blocks_in); end
         default:  begin fidx = multi_in ? 8'd25 : 8'd24; farg = arg_in; end
      endcase

      rsp = '0;
      rsp.tx_byte = 8'hFF;
      rsp.last = 1'b1;
      if (rdv) begin rsp.rd_valid = 1'b1; rsp.rd_byte = rx; end
      if (fin) begin
         rsp.done_res = 1'b1; rsp.status = fst;
      end else if (direct) begin
         rsp.tx_valid = 1'b1; rsp.tx_byte = req.wr_byte; rsp.cs_low = 1'b1;
      end else if (phase_in == PH_WREQ) begin
         rsp.need_wr = 1'b1;
      end else begin
         if (is_cmd(phase_in)) begin
            if (idx_in == 0) begin tx = 8'h40 | fidx; cs = 1'b1; end
            else if (idx_in < 5) begin
               case (idx_in[2:0])
                  3'd1:    tx = farg[31:24];
                  3'd2:    tx = farg[23:16];
                  3'd3:    tx = farg[15:8];
                  default: tx = farg[7:0];
               endcase
               cs = 1'b1;
            end else if (idx_in == 5) begin tx = fcrc; cs = 1'b1; end
            else if (idx_in < 11) cs = 1'b1;
         end else if (phase_in == PH_WTOK) begin
            tx = stok_in; cs = 1'b1;
         end else if (phase_in == PH_WSTOP) begin
            tx = 8'hFD; cs = 1'b1;
         end else if (phase_in == PH_RDTOK || phase_in == PH_RDDATA
                      || phase_in == PH_RDCRC || phase_in == PH_WCRC
                      || phase_in == PH_WDRESP || phase_in == PH_WBUSY) begin
            cs = 1'b1;
         end
         rsp.tx_valid = 1'b1; rsp.tx_byte = tx; rsp.cs_low = cs;
      end
   end

endmodule

// ===== dv/sd_spi_host_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_checker
// watches the request, response and csr ports of the sd spi host sequencer,
// predicts every response from its own model of the card sequences and
// compares each accepted response field by field in arrival order
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer_checker
   import sds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        drain_done,
   output int          fail_count
);

   // predicted sequencer state
   phase_type   seq_phase;
   logic [9:0]  byte_pos;
   logic [15:0] blocks_todo;
   logic [7:0]  retry_cnt;
   logic [15:0] poll_cnt;
   logic [7:0]  wr_token;
   logic        multi;
   logic [7:0]  ocr_hi;
   logic [31:0] cmd_arg;
   logic [7:0]  r1_latch;
   logic [15:0] poll_lim;
   logic [7:0]  retry_lim;

   rsp_type expected_rsp_q[$];
   bit      leftover_checked;

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   function automatic void enter_phase(input phase_type p);
      seq_phase = p;
      byte_pos  = '0;
      poll_cnt  = poll_lim;
   endfunction

   // command frame: index byte, four argument bytes, crc byte
   function automatic logic [7:0] frame_byte(input logic [9:0] k);
      logic [5:0]  idx;
      logic [31:0] arg;
      logic [7:0]  crc;
      logic [31:0] sh;
      idx = '0;
      arg = '0;
      crc = '0;
      case (seq_phase)
         PH_C0: crc = 8'h95;
         PH_C8: begin
            idx = 6'd8; arg = 32'h0000_01AA; crc = 8'h87;
         end
         PH_C55: idx = 6'd55;
         PH_C41: begin
            idx = 6'd41; arg = 32'h4000_0000;
         end
         PH_C58: begin
            idx = 6'd58; crc = 8'h01;
         end
         PH_RDCMD: begin
            idx = multi ? 6'd18 : 6'd17; arg = cmd_arg;
         end
         PH_C12: idx = 6'd12;
         PH_WC23: begin
            idx = 6'd23; arg = {16'h0, blocks_todo};
         end
         default: begin
            idx = multi ? 6'd25 : 6'd24; arg = cmd_arg;
         end
      endcase
      if (k == 0) return 8'h40 | {2'b00, idx};
      if (k <= 4) begin
         sh = arg >> (8 * (4 - int'(k)));
         return sh[7:0];
      end
      return crc;
   endfunction

   function automatic bit retries_gone();
      if (retry_cnt <= 1) return 1'b1;
      retry_cnt--;
      return 1'b0;
   endfunction

   function automatic int read_end_status();
      return (blocks_todo != 0) ? int'(ST_TOKEN) : int'(ST_OK);
   endfunction

   // command phases: frame, response poll, trailing bytes, decision
   function automatic int cmd_byte(input logic [7:0] rx);
      if (byte_pos < 5) begin
         byte_pos++;
         return -1;
      end
      if (byte_pos == 5) begin
         byte_pos = 10'd6;
         poll_cnt = poll_lim;
         return -1;
      end
      if (byte_pos == 6) begin
         if (rx == 8'hFF && poll_cnt > 1) begin
            poll_cnt--;
            return -1;
         end
         r1_latch = rx;
         if (seq_phase == PH_C8 || seq_phase == PH_C58) begin
            byte_pos = 10'd7;
            return -1;
         end
         if (seq_phase == PH_RDCMD && rx == 0) begin
            if (blocks_todo != 0) enter_phase(PH_RDTOK);
            else enter_phase(PH_RDEND);
            return -1;
         end
         if (seq_phase == PH_WRCMD && rx == 0) begin
            if (blocks_todo != 0) enter_phase(PH_WTOK);
            else enter_phase(PH_WSTOP);
            return -1;
         end
         byte_pos = 10'd11;
         return -1;
      end
      if (byte_pos < 11) begin
         if (byte_pos == 7 && seq_phase == PH_C58) ocr_hi = rx;
         byte_pos++;
         return -1;
      end
      case (seq_phase)
         PH_C0: begin
            if (r1_latch != 8'h01) return int'(ST_CMD0);
            enter_phase(PH_C8);
         end
         PH_C8: begin
            if (r1_latch != 8'h01) return int'(ST_CMD8);
            retry_cnt = retry_lim;
            enter_phase(PH_C55);
         end
         PH_C55: begin
            if (r1_latch != 8'h01) return int'(ST_ACMD41);
            enter_phase(PH_C41);
         end
         PH_C41: begin
            if (r1_latch == 0) begin
               retry_cnt = retry_lim;
               enter_phase(PH_C58);
            end else begin
               if (retries_gone()) return int'(ST_ACMD41);
               enter_phase(PH_C55);
            end
         end
         PH_C58: begin
            if (r1_latch == 0) return ocr_hi[6] ? int'(ST_OK) : int'(ST_NOT_HC);
            if (retries_gone()) return int'(ST_CMD58);
            enter_phase(PH_C58);
         end
         PH_C12: enter_phase(PH_RDTAIL);
         PH_WC23: enter_phase(PH_WRCMD);
         default: return int'(ST_R1_REJ);
      endcase
      return -1;
   endfunction

   // one exchanged byte; returns a status when the sequence ends, else -1
   function automatic int exchange_byte(input logic [7:0] rx);
      if (seq_phase >= PH_C0 && seq_phase <= PH_WRCMD) return cmd_byte(rx);
      case (seq_phase)
         PH_WAKE: begin
            byte_pos++;
            if (byte_pos >= 10) enter_phase(PH_C0);
         end
         PH_RDTOK: begin
            if (rx == 8'hFF && poll_cnt > 1) begin
               poll_cnt--;
               return -1;
            end
            if (rx == 8'hFE) enter_phase(PH_RDDATA);
            else enter_phase(PH_RDEND);
         end
         PH_RDDATA: begin
            byte_pos++;
            if (byte_pos >= BlockBytes) enter_phase(PH_RDCRC);
         end
         PH_RDCRC: begin
            byte_pos++;
            if (byte_pos >= 2) begin
               blocks_todo--;
               if (blocks_todo != 0) enter_phase(PH_RDTOK);
               else enter_phase(PH_RDEND);
            end
         end
         PH_RDEND: begin
            if (!multi) return read_end_status();
            enter_phase(PH_C12);
         end
         PH_RDTAIL: return read_end_status();
         PH_WTOK: enter_phase(PH_WREQ);
         PH_WDATA: begin
            byte_pos++;
            if (byte_pos >= BlockBytes) enter_phase(PH_WCRC);
            else seq_phase = PH_WREQ;
         end
         PH_WCRC: begin
            byte_pos++;
            if (byte_pos >= 2) enter_phase(PH_WDRESP);
         end
         PH_WDRESP: begin
            if ((rx & 8'h1F) == 8'h05) enter_phase(PH_WBUSY);
            else enter_phase(PH_WREJ);
         end
         PH_WBUSY: begin
            if (rx == 0) return -1;
            blocks_todo--;
            if (blocks_todo != 0) enter_phase(PH_WTOK);
            else if (multi) enter_phase(PH_WSTOP);
            else enter_phase(PH_WTAIL);
         end
         PH_WSTOP: enter_phase(PH_WTAIL);
         PH_WTAIL: begin
            byte_pos++;
            if (byte_pos >= (multi ? 10'd3 : 10'd2)) return int'(ST_OK);
         end
         default: return int'(ST_WR_REJ);
      endcase
      return -1;
   endfunction

   // one request transaction; returns 1 when it produces a response
   function automatic bit predict_rsp(input req_type r, output rsp_type o);
      int  fin;
      bit  direct;
      bit  rdv;
      fin    = -1;
      direct = 1'b0;
      rdv    = 1'b0;
      o      = '0;
      if (r.func == FUNC_INIT || r.func == FUNC_READ || r.func == FUNC_WRITE) begin
         if (seq_phase != PH_IDLE) return 1'b0;
         if (r.func == FUNC_INIT) begin
            enter_phase(PH_WAKE);
         end else begin
            blocks_todo = r.count;
            multi       = (r.count != 16'd1);
            cmd_arg     = r.sector;
            if (r.func == FUNC_READ) begin
               enter_phase(PH_RDCMD);
            end else begin
               wr_token = multi ? 8'hFC : 8'hFE;
               if (multi) enter_phase(PH_WC23);
               else enter_phase(PH_WRCMD);
            end
         end
      end else if (r.func == FUNC_XCHG) begin
         if (seq_phase == PH_IDLE || seq_phase == PH_WREQ) return 1'b0;
         rdv = (seq_phase == PH_RDDATA);
         fin = exchange_byte(r.rx_byte);
         if (fin >= 0) seq_phase = PH_IDLE;
      end else if (r.func == FUNC_WDATA) begin
         if (seq_phase != PH_WREQ) return 1'b0;
         seq_phase = PH_WDATA;
         direct    = 1'b1;
      end else begin
         return 1'b0;
      end

      o.tx_byte = 8'hFF;
      if (rdv) begin
         o.rd_valid = 1'b1;
         o.rd_byte  = r.rx_byte;
      end
      if (fin >= 0) begin
         o.done_res = 1'b1;
         o.status   = 4'(fin);
      end else if (direct) begin
         o.tx_valid = 1'b1;
         o.tx_byte  = r.wr_byte;
         o.cs_low   = 1'b1;
      end else if (seq_phase == PH_WREQ) begin
         o.need_wr = 1'b1;
      end else begin
         o.tx_valid = 1'b1;
         if (seq_phase >= PH_C0 && seq_phase <= PH_WRCMD) begin
            if (byte_pos < 6) begin
               o.tx_byte = frame_byte(byte_pos);
               o.cs_low  = 1'b1;
            end else if (byte_pos < 11) begin
               o.cs_low = 1'b1;
            end
         end else if (seq_phase == PH_WTOK) begin
            o.tx_byte = wr_token;
            o.cs_low  = 1'b1;
         end else if (seq_phase == PH_WSTOP) begin
            o.tx_byte = 8'hFD;
            o.cs_low  = 1'b1;
         end else if (seq_phase == PH_RDTOK || seq_phase == PH_RDDATA ||
                      seq_phase == PH_RDCRC || seq_phase == PH_WCRC ||
                      seq_phase == PH_WDRESP || seq_phase == PH_WBUSY) begin
            o.cs_low = 1'b1;
         end
      end
      o.last = 1'b1;
      return 1'b1;
   endfunction

   // compare, then track csr writes and new requests
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         seq_phase   = PH_IDLE;
         byte_pos    = '0;
         blocks_todo = '0;
         retry_cnt   = '0;
         poll_cnt    = '0;
         wr_token    = 8'hFF;
         multi       = 1'b0;
         ocr_hi      = '0;
         cmd_arg     = '0;
         r1_latch    = '0;
         poll_lim    = 16'd4095;
         retry_lim   = 8'd255;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(got), 32'h0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
               if (got.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
               if (got.cs_low !== want.cs_low)
                  report_mismatch("cs_low", 32'(got.cs_low), 32'(want.cs_low));
               if (got.rd_valid !== want.rd_valid)
                  report_mismatch("rd_valid", 32'(got.rd_valid), 32'(want.rd_valid));
               if (got.rd_byte !== want.rd_byte)
                  report_mismatch("rd_byte", 32'(got.rd_byte), 32'(want.rd_byte));
               if (got.need_wr !== want.need_wr)
                  report_mismatch("need_wr", 32'(got.need_wr), 32'(want.need_wr));
               if (got.done_res !== want.done_res)
                  report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.last !== want.last)
                  report_mismatch("last", 32'(got.last), 32'(want.last));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_POLL_LIMIT) poll_lim = csr_wdata;
            else retry_lim = csr_wdata[7:0];
         end
         if (req_valid && !req_stall) begin
            if (predict_rsp(req_data, pred)) expected_rsp_q.push_back(pred);
         end
         if (drain_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_rsp_q.size() != 0)
               report_mismatch("leftover transactions", expected_rsp_q.size(), 32'h0);
         end
      end
   end

endmodule

// ===== dv/tb_sd_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_sd_spi_host_sequencer
// drives the sd spi host sequencer with init, read and write sequences answered
// by a simple card emulation, plus noise, csr changes and back-pressure; the
// checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module tb_sd_spi_host_sequencer;
   import sds_pkg::*;

   localparam int CycleLimit  = 1500000;
   localparam int RandomItems = 480;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        drain_done;
   int          fail_count;

   int      cycles;
   int      rsp_seen;
   int      rsp_due;
   int      req_sent;
   rsp_type last_rsp;
   bit      hold_req;
   int      hold_cnt;

   // card emulation state
   bit          from_wdata;
   int          cmd_pos;
   logic [5:0]  cur_cmd;
   bit          ocr_next;
   int          rd_mode;
   int          rd_left;
   int          wr_cnt;
   int          wr_after;
   bit          doomed;

   sd_spi_host_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sd_spi_host_sequencer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .drain_done (drain_done),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit calm();
      return cycles >= 3000 && cycles < 6000;
   endfunction

   // cycle limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // response monitor for the card emulation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         last_rsp = rsp_data;
         rsp_seen++;
      end
   end

   // receiver: random stalls, a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_cnt  = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 60;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = !calm() && ($urandom_range(99) < 20);
         end
      end
   end

   function automatic req_type rand_req();
      req_type r;
      r.func    = 3'($urandom_range(7));
      r.sector  = $urandom;
      r.count   = 16'($urandom);
      r.rx_byte = 8'($urandom);
      r.wr_byte = 8'($urandom);
      return r;
   endfunction

   // one request transaction, entered and left at a falling edge
   task automatic send_req(input req_type r, input bit yields);
      while (!calm() && $urandom_range(99) < 20) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      req_sent++;
      if (yields) rsp_due++;
   endtask

   task automatic wait_drained();
      while (rsp_seen != rsp_due) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] v);
      wait_drained();
      repeat (3) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // byte the card returns for the exchange just asked for
   function automatic logic [7:0] card_rx();
      logic [7:0] v;
      v = 8'($urandom);
      if (!from_wdata && cmd_pos == 0 && last_rsp.cs_low && last_rsp.tx_byte[7:6] == 2'b01) begin
         cur_cmd = last_rsp.tx_byte[5:0];
         cmd_pos = 1;
         rd_mode = 0;
         return v;
      end
      if (cmd_pos > 0 && cmd_pos < 6) begin
         cmd_pos++;
         return v;
      end
      // response poll
      if (cmd_pos == 6) begin
         if ($urandom_range(9) == 0) return 8'hFF;
         cmd_pos = 0;
         if ($urandom_range(19) == 0) return v;
         case (cur_cmd)
            6'd41: v = ($urandom_range(2) == 0) ? 8'h00 : 8'h01;
            6'd58: begin
               ocr_next = 1'b1;
               v = ($urandom_range(4) == 0) ? 8'h01 : 8'h00;
            end
            6'd17, 6'd18: begin
               v = doomed ? 8'h04 : 8'h00;
               if (v == 0) rd_mode = 1;
            end
            6'd24, 6'd25: begin
               v = doomed ? 8'h04 : 8'h00;
               wr_cnt   = 0;
               wr_after = 0;
            end
            6'd0, 6'd8, 6'd55: v = 8'h01;
            default: v = 8'h00;
         endcase
         return v;
      end
      if (ocr_next) begin
         ocr_next = 1'b0;
         return ($urandom_range(3) == 0) ? v : 8'hC0;
      end
      // read data block with crc
      if (rd_mode == 2) begin
         rd_left--;
         if (rd_left == 0) rd_mode = 1;
         return v;
      end
      if (rd_mode == 1 && last_rsp.cs_low) begin
         if ($urandom_range(9) == 0) return 8'hFF;
         if ($urandom_range(29) != 0) v = 8'hFE;
         if (v == 8'hFE) begin
            rd_mode = 2;
            rd_left = BlockBytes + 2;
         end
         return v;
      end
      // data response then busy after a written block
      if (wr_cnt >= BlockBytes) begin
         wr_after++;
         if (wr_after == 4) return ($urandom_range(9) == 0) ? v : 8'hE5;
         if (wr_after > 4) begin
            v = ($urandom_range(9) < 6) ? 8'h00 : 8'hFF;
            if (v != 0) begin
               wr_cnt   = 0;
               wr_after = 0;
            end
         end
      end
      return v;
   endfunction

   // transaction the block ignores while a sequence runs
   task automatic send_noise();
      req_type r;
      r = rand_req();
      case ($urandom_range(2))
         0: r.func = 3'($urandom_range(7, 5));
         1: r.func = 3'($urandom_range(2));
         default: r.func = last_rsp.need_wr ? FUNC_XCHG : FUNC_WDATA;
      endcase
      send_req(r, 1'b0);
   endtask

   task automatic reset_card(input logic [15:0] cnt);
      from_wdata = 1'b0;
      cmd_pos    = 0;
      ocr_next   = 1'b0;
      rd_mode    = 0;
      wr_cnt     = 0;
      wr_after   = 0;
      doomed     = cnt > 3;
   endtask

   task automatic start_seq(input func_type f, input logic [31:0] sec, input logic [15:0] cnt);
      req_type r;
      reset_card(cnt);
      r        = rand_req();
      r.func   = f;
      r.sector = sec;
      r.count  = cnt;
      send_req(r, 1'b1);
   endtask

   // answer the block until its sequence reports done
   task automatic drive_seq();
      req_type r;
      forever begin
         wait_drained();
         if (last_rsp.done_res) break;
         if ($urandom_range(99) < 4) send_noise();
         r = rand_req();
         if (last_rsp.need_wr) begin
            r.func = FUNC_WDATA;
            wr_cnt++;
            from_wdata = 1'b1;
         end else begin
            r.func    = FUNC_XCHG;
            r.rx_byte = card_rx();
            from_wdata = 1'b0;
         end
         send_req(r, 1'b1);
      end
   endtask

   function automatic logic [15:0] pick_count();
      int k;
      k = $urandom_range(99);
      if (k < 10) return 16'd0;
      if (k < 55) return 16'd1;
      if (k < 80) return 16'd2;
      if (k < 85) return 16'd3;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_poll();
      case ($urandom_range(5))
         0: return 16'd1;
         1: return 16'd2;
         2: return 16'd3;
         3: return 16'hFFFF;
         4: return 16'd4095;
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_retry();
      case ($urandom_range(3))
         0: return 16'd1;
         1: return 16'd2;
         2: return 16'd255;
         default: return 16'($urandom_range(255, 1));
      endcase
   endfunction

   // stimulus and verdict
   initial begin
      req_type r;
      int      k;
      int      target;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_POLL_LIMIT;
      csr_wdata  = '0;
      drain_done = 1'b0;
      hold_req   = 1'b0;
      rsp_seen   = 0;
      rsp_due    = 0;
      req_sent   = 0;
      last_rsp   = '0;
      reset_card(16'd1);
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme limits, stray transactions while idle, empty read
      write_csr(CSR_POLL_LIMIT, 16'hFFFF);
      write_csr(CSR_RETRY_LIMIT, 16'd1);
      r = '1;
      r.func = FUNC_XCHG;
      send_req(r, 1'b0);
      r = '0;
      r.func = FUNC_WDATA;
      send_req(r, 1'b0);
      for (k = 5; k <= 7; k++) begin
         r = rand_req();
         r.func = 3'(k);
         send_req(r, 1'b0);
      end
      start_seq(FUNC_READ, 32'hFFFF_FFFF, 16'd0);
      drive_seq();
      write_csr(CSR_POLL_LIMIT, 16'd1);
      write_csr(CSR_RETRY_LIMIT, 16'd255);

      // receiver holds off while the wake bytes pile up
      hold_req = 1'b1;
      reset_card(16'd1);
      r = rand_req();
      r.func = FUNC_INIT;
      send_req(r, 1'b1);
      for (k = 0; k < 9; k++) begin
         r = rand_req();
         r.func = FUNC_XCHG;
         send_req(r, 1'b1);
      end
      drive_seq();

      // random sequences until the overall item budget is spent
      target = RandomItems;
      while (req_sent < target) begin
         if ($urandom_range(99) < 15) begin
            write_csr(CSR_POLL_LIMIT, pick_poll());
            write_csr(CSR_RETRY_LIMIT, pick_retry());
         end
         k = $urandom_range(99);
         if (k < 30) start_seq(FUNC_INIT, $urandom, 16'($urandom));
         else if (k < 65) start_seq(FUNC_READ, $urandom, pick_count());
         else start_seq(FUNC_WRITE, $urandom, pick_count());
         drive_seq();
      end

      wait_drained();
      repeat (4) @(negedge clock);
      drain_done = 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
